/* design/necir_pkg.sv */
`timescale 1ns / 1ps

package necir_pkg;

    localparam int DUR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PULSE_W    = 6;

    // pulse counter parks here until the next header
    localparam logic [PULSE_W-1:0] PULSE_LIMIT = 6'd50;
    localparam logic [PULSE_W-1:0] FRAME_BITS  = 6'd32;

    localparam logic [DUR_W-1:0] SYNC_LOW_MIN_RST  = 16'd850;
    localparam logic [DUR_W-1:0] SYNC_LOW_MAX_RST  = 16'd950;
    localparam logic [DUR_W-1:0] SYNC_HIGH_MIN_RST = 16'd400;
    localparam logic [DUR_W-1:0] SYNC_HIGH_MAX_RST = 16'd500;
    localparam logic [DUR_W-1:0] ONE_THRESH_RST    = 16'd128;
    localparam logic [2:0]       REPEAT_LOG2_RST   = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_LOW_MIN  = 3'd0,
        REG_SYNC_LOW_MAX  = 3'd1,
        REG_SYNC_HIGH_MIN = 3'd2,
        REG_SYNC_HIGH_MAX = 3'd3,
        REG_ONE_THRESH    = 3'd4,
        REG_REPEAT_LOG2   = 3'd5
    } necir_reg_idx_t;

    typedef enum logic {
        MODE_EDGE    = 1'b0,
        MODE_TIMEOUT = 1'b1
    } necir_mode_t;

    typedef struct packed {
        logic [DUR_W-1:0] sync_low_min;
        logic [DUR_W-1:0] sync_low_max;
        logic [DUR_W-1:0] sync_high_min;
        logic [DUR_W-1:0] sync_high_max;
        logic [DUR_W-1:0] one_threshold;
        logic [2:0]       repeat_log2;
    } necir_cfg_t;

    typedef struct packed {
        logic       key_strobe;
        logic       key_repeat;
        logic [7:0] address;
        logic [7:0] address_inverse;
        logic [7:0] command;
        logic [7:0] command_inverse;
        logic       pressing;
        logic       released;
    } necir_result_t;

endpackage

/* design/necir_regs.sv */
`timescale 1ns / 1ps

module necir_regs
    import necir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_wdata,
    output necir_cfg_t           cfg
);

    necir_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_low_min  <= SYNC_LOW_MIN_RST;
            cfg_reg.sync_low_max  <= SYNC_LOW_MAX_RST;
            cfg_reg.sync_high_min <= SYNC_HIGH_MIN_RST;
            cfg_reg.sync_high_max <= SYNC_HIGH_MAX_RST;
            cfg_reg.one_threshold <= ONE_THRESH_RST;
            cfg_reg.repeat_log2   <= REPEAT_LOG2_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_SYNC_LOW_MIN:  cfg_reg.sync_low_min  <= cfg_wdata;
                REG_SYNC_LOW_MAX:  cfg_reg.sync_low_max  <= cfg_wdata;
                REG_SYNC_HIGH_MIN: cfg_reg.sync_high_min <= cfg_wdata;
                REG_SYNC_HIGH_MAX: cfg_reg.sync_high_max <= cfg_wdata;
                REG_ONE_THRESH:    cfg_reg.one_threshold <= cfg_wdata;
                REG_REPEAT_LOG2:   cfg_reg.repeat_log2   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/necir_core.sv */
`timescale 1ns / 1ps

module necir_core
    import necir_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             mode,
    input  logic [DUR_W-1:0] duration,
    input  necir_cfg_t       cfg,
    output necir_result_t    result
);

    logic               expect_rising_reg, expect_rising_next;
    logic [DUR_W-1:0]   last_low_reg,      last_low_next;
    logic               press_active_reg,  press_active_next;
    logic [PULSE_W-1:0] pulse_count_reg,   pulse_count_next;
    logic [7:0]         edge_tally_reg,    edge_tally_next;
    logic               held_valid_reg,    held_valid_next;
    logic [7:0]         code_bytes_reg [4];
    logic [7:0]         code_bytes_next [4];
    logic [2:0]         byte_index_reg,    byte_index_next;

    logic       strobe;
    logic       repeat_hit;
    logic       released;
    logic       sync_ok;
    logic       one_bit;
    logic [7:0] tally_mask;

    assign sync_ok = (last_low_reg > cfg.sync_low_min) && (last_low_reg < cfg.sync_low_max)
                  && (duration > cfg.sync_high_min) && (duration < cfg.sync_high_max);
    assign one_bit    = (duration >= cfg.one_threshold);
    assign tally_mask = ~(8'hff << cfg.repeat_log2);

    always_comb begin
        expect_rising_next = expect_rising_reg;
        last_low_next      = last_low_reg;
        press_active_next  = press_active_reg;
        pulse_count_next   = pulse_count_reg;
        edge_tally_next    = edge_tally_reg;
        held_valid_next    = held_valid_reg;
        byte_index_next    = byte_index_reg;
        for (int i = 0; i < 4; i++) begin
            code_bytes_next[i] = code_bytes_reg[i];
        end
        strobe     = 1'b0;
        repeat_hit = 1'b0;
        released   = 1'b0;

        if (mode == MODE_TIMEOUT) begin
            released          = press_active_reg;
            press_active_next = 1'b0;
            held_valid_next   = 1'b0;
        end else if (expect_rising_reg) begin
            expect_rising_next = 1'b0;
            last_low_next      = duration;
        end else begin
            expect_rising_next = 1'b1;
            if (sync_ok) begin
                press_active_next = 1'b1;
                pulse_count_next  = '0;
                edge_tally_next   = '0;
                held_valid_next   = 1'b0;
                byte_index_next   = '0;
                for (int i = 0; i < 4; i++) begin
                    code_bytes_next[i] = '0;
                end
            end
            if (press_active_next) begin
                if (pulse_count_next != '0 && pulse_count_next <= FRAME_BITS) begin
                    for (int i = 0; i < 4; i++) begin
                        if (byte_index_next[1:0] == 2'(i)) begin
                            code_bytes_next[i] = {one_bit, code_bytes_next[i][7:1]};
                        end
                    end
                    if (pulse_count_next[2:0] == 3'd0) begin
                        byte_index_next = byte_index_next + 3'd1;
                    end
                end
                if (held_valid_next && ((edge_tally_next & tally_mask) == 8'd0)) begin
                    strobe     = 1'b1;
                    repeat_hit = 1'b1;
                end
                // fresh key wins over a repeat on the same edge
                if (pulse_count_next == FRAME_BITS
                    && (code_bytes_next[2] ^ code_bytes_next[3]) == 8'hff) begin
                    strobe          = 1'b1;
                    repeat_hit      = 1'b0;
                    held_valid_next = 1'b1;
                end
                if (pulse_count_next < PULSE_LIMIT) begin
                    pulse_count_next = pulse_count_next + 6'd1;
                end
                edge_tally_next = edge_tally_next + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_rising_reg <= 1'b0;
            last_low_reg      <= '0;
            press_active_reg  <= 1'b0;
            pulse_count_reg   <= '0;
            edge_tally_reg    <= '0;
            held_valid_reg    <= 1'b0;
            byte_index_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                code_bytes_reg[i] <= '0;
            end
        end else if (accept) begin
            expect_rising_reg <= expect_rising_next;
            last_low_reg      <= last_low_next;
            press_active_reg  <= press_active_next;
            pulse_count_reg   <= pulse_count_next;
            edge_tally_reg    <= edge_tally_next;
            held_valid_reg    <= held_valid_next;
            byte_index_reg    <= byte_index_next;
            for (int i = 0; i < 4; i++) begin
                code_bytes_reg[i] <= code_bytes_next[i];
            end
        end
    end

    always_comb begin
        result.key_strobe      = strobe;
        result.key_repeat      = repeat_hit;
        result.address         = code_bytes_next[0];
        result.address_inverse = code_bytes_next[1];
        result.command         = code_bytes_next[2];
        result.command_inverse = code_bytes_next[3];
        result.pressing        = press_active_next;
        result.released        = released;
    end

endmodule

/* design/nec_ir_frame_decoder.sv */
// The result of a beat accepted at one edge is registered and is on m_* after that edge.
// Throughput: 1 beat per cycle; the single output register is the only stage and
// takes a new result whenever it is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): decoder state clears, registers load their
// defaults, and the output register empties.
`timescale 1ns / 1ps

module nec_ir_frame_decoder
    import necir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [DUR_W-1:0]     s_duration,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_key_strobe,
    output logic                 m_key_repeat,
    output logic [7:0]           m_address,
    output logic [7:0]           m_address_inverse,
    output logic [7:0]           m_command,
    output logic [7:0]           m_command_inverse,
    output logic                 m_pressing,
    output logic                 m_released
);

    necir_cfg_t    cfg;
    necir_result_t result;
    necir_result_t out_reg;
    logic          m_valid_reg;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    necir_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    necir_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .mode     (s_mode),
        .duration (s_duration),
        .cfg      (cfg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_key_strobe      = out_reg.key_strobe;
    assign m_key_repeat      = out_reg.key_repeat;
    assign m_address         = out_reg.address;
    assign m_address_inverse = out_reg.address_inverse;
    assign m_command         = out_reg.command;
    assign m_command_inverse = out_reg.command_inverse;
    assign m_pressing        = out_reg.pressing;
    assign m_released        = out_reg.released;

endmodule

/* design/necir_checker.sv */
`timescale 1ns / 1ps

module necir_checker
    import necir_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_key_strobe,
    input logic                 m_key_repeat,
    input logic [7:0]           m_address,
    input logic [7:0]           m_command,
    input logic                 m_pressing,
    input logic                 m_released
);

    // an empty output stage never holds off the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output stage");

    a_repeat_needs_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_key_repeat) |-> m_key_strobe)
        else $error("repeat flag without strobe");

    a_strobe_while_pressing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_key_strobe) |-> (m_pressing && !m_released))
        else $error("strobe outside an active press");

    a_release_ends_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_released) |-> !m_pressing)
        else $error("release beat still shows pressing");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_address) && $stable(m_command)
                                   && $stable(m_key_strobe)))
        else $error("result beat changed while stalled");

endmodule

bind nec_ir_frame_decoder necir_checker u_necir_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_key_strobe (m_key_strobe),
    .m_key_repeat (m_key_repeat),
    .m_address    (m_address),
    .m_command    (m_command),
    .m_pressing   (m_pressing),
    .m_released   (m_released)
);
